// ===== hdl/zrld_pkg.sv =====
// Shared types and constants of the zero-run line decoder.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps

package zrld_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned DIM_W      = 12;
    localparam int unsigned LEN_W      = 9;
    localparam int unsigned FLT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FLT_W-1:0] FAULT_OK      = 2'd0;
    localparam logic [FLT_W-1:0] FAULT_MARGIN  = 2'd1;
    localparam logic [FLT_W-1:0] FAULT_OVERRUN = 2'd2;

    // Depth of the command queue between front and back.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_INNER,
        PH_COUNT
    } t_phase;

    typedef struct packed {
        logic [7:0]       pix;
        logic [LEN_W-1:0] len;
        logic             line_end;
        logic             frame_end;
        logic [FLT_W-1:0] fault;
    } t_run;

    // One decoded item: one or two runs.
    typedef struct packed {
        logic two;
        t_run run0;
        t_run run1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/zrld_front.sv =====
// Front end of the decoder: accepts coded bytes, tracks the line phase and
// turns each byte into zero, one or two runs. Depends on zrld_pkg.
`timescale 1ns / 1ps

module zrld_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [zrld_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [zrld_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_push,
    input  logic [7:0]                       i_code_byte,
    input  zrld_pkg::t_q_stat                i_q_stat,
    output logic                             o_full,
    output logic                             o_cmd_wr,
    output zrld_pkg::t_cmd                   o_cmd
);

    logic [zrld_pkg::DIM_W-1:0] r_width, r_height;
    zrld_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                 r_left, n_left, r_right, n_right;
    logic [zrld_pkg::DIM_W-1:0] r_inner, n_inner, r_lines, n_lines;

    logic                             w_acc;
    logic [zrld_pkg::DIM_W:0]         w_ld_inc;
    logic                             w_fe;
    logic [zrld_pkg::DIM_W-1:0]       w_ld_fin;
    logic [8:0]                       w_msum;
    logic [zrld_pkg::DIM_W-1:0]       w_msum_x, w_inner_new;
    logic [zrld_pkg::LEN_W-1:0]       w_cnt_run;
    logic                             w_end_inner;
    logic [7:0]                       w_pix;
    logic [zrld_pkg::LEN_W-1:0]       w_len;
    logic [zrld_pkg::FLT_W-1:0]       w_flt;
    logic [zrld_pkg::DIM_W-1:0]       w_rem;
    logic                             w_has;

    assign o_full = i_q_stat.full;
    assign w_acc  = i_push && !i_q_stat.full;

    // Line counter step shared by every path that closes a line.
    assign w_ld_inc = {1'b0, r_lines} + {{zrld_pkg::DIM_W{1'b0}}, 1'b1};
    assign w_fe     = w_ld_inc[zrld_pkg::DIM_W]
                   || (w_ld_inc[zrld_pkg::DIM_W-1:0] >= r_height);
    assign w_ld_fin = w_fe ? '0 : w_ld_inc[zrld_pkg::DIM_W-1:0];

    assign w_msum      = {1'b0, r_left} + {1'b0, i_code_byte};
    assign w_msum_x    = {3'b000, w_msum};
    assign w_inner_new = r_width - w_msum_x;
    assign w_cnt_run   = {1'b0, i_code_byte} + 9'd1;

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_right     = r_right;
        n_inner     = r_inner;
        n_lines     = r_lines;
        w_has       = 1'b0;
        o_cmd       = '0;
        w_end_inner = 1'b0;
        w_pix       = 8'd0;
        w_len       = '0;
        w_flt       = zrld_pkg::FAULT_OK;
        w_rem       = r_inner;
        unique case (r_phase)
            zrld_pkg::PH_LEFT: begin
                n_left  = i_code_byte;
                n_phase = zrld_pkg::PH_RIGHT;
            end
            zrld_pkg::PH_RIGHT: begin
                n_right = i_code_byte;
                if (w_msum_x > r_width) begin
                    n_lines = w_ld_fin;
                    n_phase = zrld_pkg::PH_LEFT;
                    w_has   = 1'b1;
                    o_cmd.run0.line_end  = 1'b1;
                    o_cmd.run0.frame_end = w_fe;
                    o_cmd.run0.fault     = zrld_pkg::FAULT_MARGIN;
                end else begin
                    n_inner = w_inner_new;
                    if (w_inner_new != '0) begin
                        n_phase = zrld_pkg::PH_INNER;
                        if (r_left != 8'd0) begin
                            w_has         = 1'b1;
                            o_cmd.run0.len = {1'b0, r_left};
                        end
                    end else begin
                        n_lines = w_ld_fin;
                        n_phase = zrld_pkg::PH_LEFT;
                        w_has   = 1'b1;
                        if (r_left != 8'd0 && i_code_byte != 8'd0) begin
                            // Both margin runs carry the frame end flag here.
                            o_cmd.two            = 1'b1;
                            o_cmd.run0.len       = {1'b0, r_left};
                            o_cmd.run0.frame_end = w_fe;
                            o_cmd.run1.len       = {1'b0, i_code_byte};
                            o_cmd.run1.line_end  = 1'b1;
                            o_cmd.run1.frame_end = w_fe;
                        end else begin
                            // Only one margin, or an empty line marker.
                            o_cmd.run0.len       = {1'b0, r_left | i_code_byte};
                            o_cmd.run0.line_end  = 1'b1;
                            o_cmd.run0.frame_end = w_fe;
                        end
                    end
                end
            end
            zrld_pkg::PH_INNER: begin
                if (i_code_byte == 8'd0) begin
                    n_phase = zrld_pkg::PH_COUNT;
                end else begin
                    w_end_inner = 1'b1;
                    w_pix       = i_code_byte;
                    w_len       = 9'd1;
                    w_rem       = r_inner - 12'd1;
                end
            end
            zrld_pkg::PH_COUNT: begin
                w_end_inner = 1'b1;
                n_phase     = zrld_pkg::PH_INNER;
                if ({3'b000, w_cnt_run} > r_inner) begin
                    // The inner remainder is below the run here, so it fits.
                    w_len = r_inner[zrld_pkg::LEN_W-1:0];
                    w_flt = zrld_pkg::FAULT_OVERRUN;
                    w_rem = '0;
                end else begin
                    w_len = w_cnt_run;
                    w_rem = r_inner - {3'b000, w_cnt_run};
                end
            end
            default: begin
                n_phase = zrld_pkg::PH_LEFT;
            end
        endcase

        if (w_end_inner) begin
            n_inner         = w_rem;
            w_has           = 1'b1;
            o_cmd.run0.pix  = w_pix;
            o_cmd.run0.len  = w_len;
            o_cmd.run0.fault = w_flt;
            if (w_rem == '0) begin
                n_lines = w_ld_fin;
                n_phase = zrld_pkg::PH_LEFT;
                if (r_right != 8'd0) begin
                    o_cmd.two            = 1'b1;
                    o_cmd.run1.len       = {1'b0, r_right};
                    o_cmd.run1.line_end  = 1'b1;
                    o_cmd.run1.frame_end = w_fe;
                end else begin
                    o_cmd.run0.line_end  = 1'b1;
                    o_cmd.run0.frame_end = w_fe;
                end
            end
        end
    end

    assign o_cmd_wr = w_acc && w_has;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == zrld_pkg::CFG_FRAME_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= zrld_pkg::PH_LEFT;
            r_left  <= '0;
            r_right <= '0;
            r_inner <= '0;
            r_lines <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_right <= n_right;
            r_inner <= n_inner;
            r_lines <= n_lines;
        end
    end

endmodule

// ===== hdl/zrld_cmd_fifo.sv =====
// Short command queue between the decoder front and back ends.
// Depends on zrld_pkg for the command type and depth.
`timescale 1ns / 1ps

module zrld_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  zrld_pkg::t_cmd     i_cmd,
    input  logic               i_rd,
    output zrld_pkg::t_cmd     o_cmd,
    output zrld_pkg::t_q_stat  o_stat
);

    zrld_pkg::t_cmd                r_mem [zrld_pkg::QDEPTH];
    logic [zrld_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [zrld_pkg::QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == zrld_pkg::QCNT_W'(zrld_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cmd        = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_wr, i_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/zrld_back.sv =====
// Back end of the decoder: takes commands from the queue and presents their
// runs one at a time in an output register. Depends on zrld_pkg.
`timescale 1ns / 1ps

module zrld_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zrld_pkg::t_q_stat  i_q_stat,
    input  zrld_pkg::t_cmd     i_cmd,
    output logic               o_cmd_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output zrld_pkg::t_run     o_run
);

    logic           r_valid, n_valid;
    logic           r_pend_valid, n_pend_valid;
    zrld_pkg::t_run r_out, n_out, r_pend, n_pend;
    logic           w_take;

    assign w_take  = !r_valid || i_pop;
    assign o_empty = !r_valid;
    assign o_run   = r_out;

    always_comb begin
        n_valid      = r_valid;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_pend       = r_pend;
        o_cmd_rd     = 1'b0;
        if (w_take) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_valid      = 1'b1;
                n_pend_valid = 1'b0;
            end else if (!i_q_stat.empty) begin
                o_cmd_rd     = 1'b1;
                n_out        = i_cmd.run0;
                n_valid      = 1'b1;
                n_pend       = i_cmd.run1;
                n_pend_valid = i_cmd.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

// ===== hdl/zero_run_line_decoder_core.sv =====
// Top level of the zero-run line decoder: front end, command queue, back end.
// Depends on zrld_pkg, zrld_front, zrld_cmd_fifo and zrld_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// coded in  input      push / full        i_code_byte
// runs out  output     empty / pop        o_pixel_value, o_run_length, o_line_end,
//                                         o_frame_end, o_fault
// config    input      i_cfg_we           i_cfg_idx, i_cfg_data
//
// One coded byte is accepted per cycle whenever the four-entry command queue has
// room; a byte yields zero, one or two runs, and the back end delivers one run per
// cycle while pop is held, so sustained input rate is one byte per cycle unless
// two-run bytes pile up. The first run of a byte passes through the queue and the
// output register; a second run waits in a pending register for the next pop.
// Reset is synchronous and active low; it clears the line state, the queue and
// the output valid flags, with no clearing pass. A stalled output holds its run while
// the queue absorbs the front end's work until it fills and full is raised.

module zero_run_line_decoder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [zrld_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [zrld_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_code_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_pixel_value,
    output logic [zrld_pkg::LEN_W-1:0]       o_run_length,
    output logic                             o_line_end,
    output logic                             o_frame_end,
    output logic [zrld_pkg::FLT_W-1:0]       o_fault
);

    zrld_pkg::t_q_stat w_q_stat;
    zrld_pkg::t_cmd    w_wr_cmd, w_rd_cmd;
    logic              w_wr, w_rd;
    zrld_pkg::t_run    w_run;

    // The front end decodes the line structure and writes one command per
    // byte that produces output; bytes that yield no run write nothing.
    zrld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_code_byte (i_code_byte),
        .i_q_stat    (w_q_stat),
        .o_full      (full),
        .o_cmd_wr    (w_wr),
        .o_cmd       (w_wr_cmd)
    );

    // The queue decouples decoding from delivery so either side may stall.
    zrld_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_wr_cmd),
        .i_rd    (w_rd),
        .o_cmd   (w_rd_cmd),
        .o_stat  (w_q_stat)
    );

    // The back end splits two-run commands and holds the oldest run for pop.
    zrld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_cmd    (w_rd_cmd),
        .o_cmd_rd (w_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_run    (w_run)
    );

    assign o_pixel_value = w_run.pix;
    assign o_run_length  = w_run.len;
    assign o_line_end    = w_run.line_end;
    assign o_frame_end   = w_run.frame_end;
    assign o_fault       = w_run.fault;

    // A margin fault is reported as an empty transparent line-ending run.
    a_margin_fault : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_fault == zrld_pkg::FAULT_MARGIN)
        |-> (o_run_length == '0) && o_line_end && (o_pixel_value == 8'd0))
        else $error("malformed margin fault run");

    // An empty run exists only as a line marker, and a colored pixel is a single pixel.
    a_run_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_pixel_value != 8'd0) |-> (o_run_length == 9'd1))
        else $error("colored run longer than one pixel");

    a_empty_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_run_length == '0) |-> o_line_end)
        else $error("empty run that does not end a line");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for zero_run_line_decoder_core: directed lines, then
// random well-formed and broken lines under several frame sizes, checked run by run.
// Depends on zrld_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;

    import zrld_pkg::*;

    // Cycles in a row with no item accepted on either side before the run is
    // declared hung. It leaves a wide margin over the slowest legal stretch
    // (sender gap, two runs each held by a full receiver stall, the pipeline,
    // drain hold-off and register writes).
    localparam int QUIET_LIMIT = 2000;
    // Cycles to let pass after the last expected run before touching registers
    // or ending.
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES = 6;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_code_byte = 8'd0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           o_pixel_value;
    logic [LEN_W-1:0]     o_run_length;
    logic                 o_line_end;
    logic                 o_frame_end;
    logic [FLT_W-1:0]     o_fault;

    zero_run_line_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_code_byte   (i_code_byte),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_value (o_pixel_value),
        .o_run_length  (o_run_length),
        .o_line_end    (o_line_end),
        .o_frame_end   (o_frame_end),
        .o_fault       (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Coded bytes waiting to be sent, and runs the decoder still owes us.
    logic [7:0] code_pending[$];
    t_run       runs_due[$];
    int         bad_runs = 0;
    int         push_gap = 0;
    int         pop_stall = 0;
    int         quiet_cycles = 0;
    // When set, neither side inserts idle cycles.
    bit         steady = 1'b0;

    // Our own copy of the decoder's registers and line state.
    logic [11:0] frame_w = 12'd0;
    logic [11:0] frame_h = 12'd0;
    t_phase      dec_phase = PH_LEFT;
    logic [7:0]  left_m = 8'd0;
    logic [7:0]  right_m = 8'd0;
    logic [11:0] inner_left = 12'd0;
    logic [11:0] lines_seen = 12'd0;

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic void expect_run(input logic [7:0] pix, input logic [LEN_W-1:0] len,
                                       input logic le, input logic fe,
                                       input logic [FLT_W-1:0] flt);
        t_run r;
        r.pix = pix;
        r.len = len;
        r.line_end = le;
        r.frame_end = fe;
        r.fault = flt;
        runs_due.push_back(r);
    endfunction

    // Ends the current line and tells whether it was the last of the frame.
    // A height of zero behaves like one, and the line count wraps to zero on
    // the frame's last line.
    function automatic logic close_line();
        logic last;
        last = (13'(lines_seen) + 13'd1 >= 13'(frame_h));
        lines_seen = last ? 12'd0 : lines_seen + 12'd1;
        dec_phase = PH_LEFT;
        return last;
    endfunction

    // Emits the run that finished an inner code; when it also finished the
    // inner part, the right margin run (if any) follows and carries line_end.
    function automatic void finish_inner(input logic [7:0] pix, input logic [LEN_W-1:0] len,
                                         input logic [FLT_W-1:0] flt);
        logic fe;
        if (inner_left != 12'd0) begin
            expect_run(pix, len, 1'b0, 1'b0, flt);
        end else begin
            fe = close_line();
            if (right_m != 8'd0) begin
                expect_run(pix, len, 1'b0, 1'b0, flt);
                expect_run(8'd0, LEN_W'(right_m), 1'b1, fe, FAULT_OK);
            end else begin
                expect_run(pix, len, 1'b1, fe, flt);
            end
        end
    endfunction

    // Advances the line state by one coded byte and queues the runs it yields.
    function automatic void decode_byte(input logic [7:0] b);
        logic             fe;
        logic [LEN_W-1:0] run_len;
        logic [FLT_W-1:0] flt;
        case (dec_phase)
            PH_LEFT: begin
                left_m = b;
                dec_phase = PH_RIGHT;
            end
            PH_RIGHT: begin
                right_m = b;
                if (13'(left_m) + 13'(right_m) > 13'(frame_w)) begin
                    // Margins do not fit: the line ends on a bare fault marker.
                    fe = close_line();
                    expect_run(8'd0, '0, 1'b1, fe, FAULT_MARGIN);
                end else begin
                    inner_left = frame_w - 12'(left_m) - 12'(right_m);
                    if (inner_left != 12'd0) begin
                        dec_phase = PH_INNER;
                        if (left_m != 8'd0)
                            expect_run(8'd0, LEN_W'(left_m), 1'b0, 1'b0, FAULT_OK);
                    end else begin
                        // No inner part: the margins alone make up the line.
                        fe = close_line();
                        if (left_m != 8'd0)
                            expect_run(8'd0, LEN_W'(left_m), right_m == 8'd0, fe, FAULT_OK);
                        if (right_m != 8'd0)
                            expect_run(8'd0, LEN_W'(right_m), 1'b1, fe, FAULT_OK);
                        if (left_m == 8'd0 && right_m == 8'd0)
                            expect_run(8'd0, '0, 1'b1, fe, FAULT_OK);
                    end
                end
            end
            PH_INNER: begin
                if (b == 8'd0) begin
                    dec_phase = PH_COUNT;
                end else begin
                    inner_left = inner_left - 12'd1;
                    finish_inner(b, LEN_W'(1), FAULT_OK);
                end
            end
            default: begin
                // A zero run longer than what is left of the line is cut short.
                run_len = LEN_W'(b) + LEN_W'(1);
                flt = FAULT_OK;
                if (12'(run_len) > inner_left) begin
                    run_len = LEN_W'(inner_left);
                    flt = FAULT_OVERRUN;
                end
                inner_left = inner_left - 12'(run_len);
                dec_phase = PH_INNER;
                finish_inner(8'd0, run_len, flt);
            end
        endcase
    endfunction

    // Prints one line per bad run and counts every one of them.
    task automatic flag_run(input string what);
        bad_runs++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Queues one line of code bytes for the current width and returns how many
    // bytes it took. Mostly the margins fit and the inner codes fill the line
    // exactly; now and then the margins are drawn freely (and may not fit) or a
    // zero run is drawn too long for what is left of the line. With long_runs
    // set, zero runs are near their largest so that very wide lines stay short.
    function automatic int queue_line(input int w, input bit long_runs);
        int lm;
        int rm;
        int rem;
        int cap;
        int cnt;
        int n;
        if ($urandom_range(0, 9) == 0) begin
            lm = $urandom_range(0, 255);
            rm = $urandom_range(0, 255);
        end else begin
            lm = $urandom_range(0, (w < 255) ? w : 255);
            rm = $urandom_range(0, (w - lm < 255) ? w - lm : 255);
            if ($urandom_range(0, 4) == 0)
                lm = 0;
            if ($urandom_range(0, 4) == 0)
                rm = 0;
        end
        code_pending.push_back(8'(lm));
        code_pending.push_back(8'(rm));
        n = 2;
        if (lm + rm > w)
            return n;
        rem = w - lm - rm;
        while (rem > 0) begin
            if (!long_runs && $urandom_range(0, 1) == 0) begin
                code_pending.push_back(8'($urandom_range(1, 255)));
                rem--;
                n++;
            end else begin
                cap = (rem - 1 < 255) ? rem - 1 : 255;
                if ($urandom_range(0, 15) == 0)
                    cnt = $urandom_range(0, 255);
                else if (long_runs)
                    cnt = cap - int'($urandom_range(0, cap / 4));
                else
                    cnt = $urandom_range(0, cap);
                code_pending.push_back(8'd0);
                code_pending.push_back(8'(cnt));
                rem = rem - ((cnt + 1 < rem) ? cnt + 1 : rem);
                n += 2;
            end
        end
        return n;
    endfunction

    // Driver: sends the pending code bytes, holding each one while full is
    // high and drawing an idle gap after every accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            push_gap = 0;
        end else if (!(push && full)) begin
            if (push)
                push_gap = draw_gap();
            else if (push_gap > 0)
                push_gap--;
            if (push_gap == 0 && code_pending.size() != 0) begin
                i_code_byte <= code_pending.pop_front();
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: predicts from each accepted code byte first, then checks any
    // accepted run against the oldest one still owed. Doing both in one block
    // keeps the result free of the scheduling order between separate blocks.
    always @(posedge i_clk) begin
        t_run got;
        t_run want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_stall = 0;
        end else begin
            if (push && !full)
                decode_byte(i_code_byte);
            if (pop && !empty) begin
                got.pix = o_pixel_value;
                got.len = o_run_length;
                got.line_end = o_line_end;
                got.frame_end = o_frame_end;
                got.fault = o_fault;
                if (runs_due.size() == 0) begin
                    flag_run($sformatf("run pix=%0d len=%0d le=%0b fe=%0b fault=%0d not expected",
                                       got.pix, got.len, got.line_end, got.frame_end, got.fault));
                end else begin
                    want = runs_due.pop_front();
                    if (got !== want)
                        flag_run($sformatf({"got pix=%0d len=%0d le=%0b fe=%0b fault=%0d, ",
                                            "want pix=%0d len=%0d le=%0b fe=%0b fault=%0d"},
                                           got.pix, got.len, got.line_end, got.frame_end,
                                           got.fault, want.pix, want.len, want.line_end,
                                           want.frame_end, want.fault));
                end
                pop_stall = draw_gap();
            end else if (!pop && pop_stall > 0) begin
                pop_stall--;
            end
            pop <= (pop_stall == 0);
        end
    end

    // Watchdog: a hung decoder shows up as a long stretch with no item moving.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("zero_run_line_decoder_core verification failed");
                $finish;
            end
        end
    end

    // Waits until every queued byte is in and every owed run is out, then lets
    // the pipeline settle, since the last bytes may have been ones that yield
    // no run and could still be in flight.
    task automatic drain();
        @(negedge i_clk);
        while (code_pending.size() != 0 || push || runs_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_FRAME_WIDTH)
            frame_w = val;
        else
            frame_h = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phases: widths from one pixel up to the largest, heights from the
    // degenerate zero up to the largest. One phase runs without idle cycles.
    int unsigned phase_w[NUM_PHASES] = '{16, 1, 255, 4095, 6, 40};
    int unsigned phase_h[NUM_PHASES] = '{4, 4095, 1, 7, 0, 2};
    int          phase_len[NUM_PHASES] = '{300, 100, 150, 150, 200, 400};

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset width and height of zero: an empty line marker that
        // also ends the frame, then two margin faults, one with both margins
        // at their largest.
        code_pending = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd255};
        drain();
        write_reg(CFG_FRAME_WIDTH, 12'd8);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        @(negedge i_clk);
        // Eight-pixel lines: both margins with a one-pixel zero run around a
        // pixel, a pixel then a zero run far past the line end, margins that
        // fill the line exactly, and lines that are all left or all right margin.
        code_pending = '{8'd2, 8'd3, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0,
                         8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
                         8'd4, 8'd4, 8'd8, 8'd0, 8'd0, 8'd8};
        drain();

        // A width change in the middle of a line must not disturb it: the line
        // keeps its three remaining pixels, and the zero run that follows is
        // cut to them before the right margin closes the line.
        code_pending = '{8'd3, 8'd1, 8'd9};
        drain();
        write_reg(CFG_FRAME_WIDTH, 12'd2);
        @(negedge i_clk);
        code_pending = '{8'd0, 8'd5};

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_reg(CFG_FRAME_WIDTH, 12'(phase_w[p]));
            write_reg(CFG_FRAME_HEIGHT, 12'(phase_h[p]));
            @(negedge i_clk);
            steady = (p == 4);
            sent = 0;
            while (sent < phase_len[p] / 2)
                sent += queue_line(phase_w[p], phase_w[p] > 255);
            // The sender stops here until every owed run has come back.
            drain();
            while (sent < phase_len[p])
                sent += queue_line(phase_w[p], phase_w[p] > 255);
        end
        drain();

        if (bad_runs == 0)
            $display("zero_run_line_decoder_core verification clean");
        else
            $display("zero_run_line_decoder_core verification failed");
        $finish;
    end

endmodule
